// ----- src/tgfw_pkg.sv -----
`default_nettype none
package tgfw_pkg;

	localparam int PixelColumnsDefault = 128;
	localparam int TextPagesDefault = 4;
	localparam int CellWidth = 6;
	localparam int GlyphCount = 96;

	// Request actions.
	typedef enum logic [2:0] {
		ACT_DRAW_FLOW   = 3'd0,
		ACT_DRAW_CURSOR = 3'd1,
		ACT_SET_CURSOR  = 3'd2,
		ACT_NEWLINE     = 3'd3,
		ACT_CLEAR       = 3'd4,
		ACT_READ        = 3'd5,
		ACT_NONE6       = 3'd6,
		ACT_NONE7       = 3'd7
	} action_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_CLEAR,
		ST_DRAW,
		ST_READ,
		ST_READ_WAIT,
		ST_DONE,
		ST_INIT
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load_req;
		logic decide;
		logic clear_write;
		logic clear_positions;
		logic draw_write;
		logic read_issue;
		logic read_capture;
		logic finish;
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic need_pre_clear;
		logic do_draw;
		logic need_post_clear;
		logic is_read;
		logic clear_last;
		logic draw_last;
	} stat_t;

	// Glyph column lookup; column 5 and beyond is blank.
	function automatic logic [7:0] glyph_col(input logic [7:0] code, input logic [2:0] k);
		logic [6:0] idx;
		logic [39:0] g;
		logic [7:0] c;
		c = (code < 8'h20 || code > 8'h7F) ? 8'h3F : code;
		idx = 7'(c - 8'h20);
		case (idx)
			7'd0: g = 40'h0000000000; 7'd1: g = 40'h00005F0000;
			7'd2: g = 40'h0003000300; 7'd3: g = 40'h147F147F14;
			7'd4: g = 40'h242A7F2A12; 7'd5: g = 40'h2313086462;
			7'd6: g = 40'h3649552250; 7'd7: g = 40'h0005030000;
			7'd8: g = 40'h001C224100; 7'd9: g = 40'h0041221C00;
			7'd10: g = 40'h14083E0814; 7'd11: g = 40'h08083E0808;
			7'd12: g = 40'h0050300000; 7'd13: g = 40'h0808080808;
			7'd14: g = 40'h0060600000; 7'd15: g = 40'h2010080402;
			7'd16: g = 40'h3E5149453E; 7'd17: g = 40'h00427F4000;
			7'd18: g = 40'h4261514946; 7'd19: g = 40'h2141454B31;
			7'd20: g = 40'h1814127F10; 7'd21: g = 40'h2745454539;
			7'd22: g = 40'h3C4A494930; 7'd23: g = 40'h0171090503;
			7'd24: g = 40'h3649494936; 7'd25: g = 40'h064949291E;
			7'd26: g = 40'h0036360000; 7'd27: g = 40'h0056360000;
			7'd28: g = 40'h0814224100; 7'd29: g = 40'h1414141414;
			7'd30: g = 40'h0041221408; 7'd31: g = 40'h0201510906;
			7'd32: g = 40'h324979413E; 7'd33: g = 40'h7E1111117E;
			7'd34: g = 40'h7F49494936; 7'd35: g = 40'h3E41414122;
			7'd36: g = 40'h7F4141221C; 7'd37: g = 40'h7F49494941;
			7'd38: g = 40'h7F09090901; 7'd39: g = 40'h3E4149497A;
			7'd40: g = 40'h7F0808087F; 7'd41: g = 40'h00417F4100;
			7'd42: g = 40'h2040413F01; 7'd43: g = 40'h7F08142241;
			7'd44: g = 40'h7F40404040; 7'd45: g = 40'h7F0204027F;
			7'd46: g = 40'h7F0408107F; 7'd47: g = 40'h3E4141413E;
			7'd48: g = 40'h7F09090906; 7'd49: g = 40'h3E4151215E;
			7'd50: g = 40'h7F09192946; 7'd51: g = 40'h4649494931;
			7'd52: g = 40'h01017F0101; 7'd53: g = 40'h3F4040403F;
			7'd54: g = 40'h1F2040201F; 7'd55: g = 40'h7F2010207F;
			7'd56: g = 40'h6314081463; 7'd57: g = 40'h0708700807;
			7'd58: g = 40'h6151494543; 7'd59: g = 40'h007F414100;
			7'd60: g = 40'h0204081020; 7'd61: g = 40'h0041417F00;
			7'd62: g = 40'h0402010204; 7'd63: g = 40'h8080808080;
			7'd64: g = 40'h0003070000; 7'd65: g = 40'h2054545478;
			7'd66: g = 40'h7F48444438; 7'd67: g = 40'h3844444420;
			7'd68: g = 40'h384444487F; 7'd69: g = 40'h3854545418;
			7'd70: g = 40'h087E090102; 7'd71: g = 40'h085454543C;
			7'd72: g = 40'h7F08040478; 7'd73: g = 40'h00447D4000;
			7'd74: g = 40'h2040443D00; 7'd75: g = 40'h7F10284400;
			7'd76: g = 40'h00417F4000; 7'd77: g = 40'h7C0418047C;
			7'd78: g = 40'h7C08040478; 7'd79: g = 40'h3844444438;
			7'd80: g = 40'h7C14141408; 7'd81: g = 40'h081414147C;
			7'd82: g = 40'h7C08040408; 7'd83: g = 40'h4854545420;
			7'd84: g = 40'h043F444020; 7'd85: g = 40'h3C4040207C;
			7'd86: g = 40'h1C2040201C; 7'd87: g = 40'h3C4030403C;
			7'd88: g = 40'h4428102844; 7'd89: g = 40'h0C5050503C;
			7'd90: g = 40'h4464544C44; 7'd91: g = 40'h0008364100;
			7'd92: g = 40'h00007F0000; 7'd93: g = 40'h0041360800;
			7'd94: g = 40'h0804081008;
			default: g = 40'h0000000000;
		endcase
		case (k)
			3'd0: glyph_col = g[39:32];
			3'd1: glyph_col = g[31:24];
			3'd2: glyph_col = g[23:16];
			3'd3: glyph_col = g[15:8];
			3'd4: glyph_col = g[7:0];
			default: glyph_col = 8'h00;
		endcase
	endfunction

endpackage
`default_nettype wire

// ----- src/tgfw_ram.sv -----
`default_nettype none
module tgfw_ram #(
	parameter int Width = 8,
	parameter int Depth = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- src/tgfw_ctrl.sv -----
`default_nettype none
module tgfw_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic                cfg_ready,
	input  wire tgfw_pkg::stat_t st,
	output tgfw_pkg::cmd_t      cmd
);

	tgfw_pkg::state_t state_q, state_d;
	logic post_q, post_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tgfw_pkg::ST_INIT;
			post_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			post_q  <= post_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		post_d = post_q;
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		cfg_ready = 1'b0;
		case (state_q)
			tgfw_pkg::ST_INIT: begin
				// Zero the frame store once after reset.
				cmd.clear_write = 1'b1;
				if (st.clear_last) begin
					state_d = tgfw_pkg::ST_IDLE;
				end
			end
			tgfw_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cfg_ready = !in_valid;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d = tgfw_pkg::ST_DECIDE;
				end
			end
			tgfw_pkg::ST_DECIDE: begin
				cmd.decide = 1'b1;
				post_d = st.need_post_clear;
				if (st.need_pre_clear) begin
					state_d = tgfw_pkg::ST_CLEAR;
				end else if (st.do_draw) begin
					state_d = tgfw_pkg::ST_DRAW;
				end else if (st.is_read) begin
					state_d = tgfw_pkg::ST_READ;
				end else begin
					state_d = tgfw_pkg::ST_DONE;
				end
			end
			tgfw_pkg::ST_CLEAR: begin
				cmd.clear_write = 1'b1;
				if (st.clear_last) begin
					cmd.clear_positions = 1'b1;
					state_d = st.do_draw && !post_q ? tgfw_pkg::ST_DRAW : tgfw_pkg::ST_DONE;
					post_d = 1'b0;
				end
			end
			tgfw_pkg::ST_DRAW: begin
				cmd.draw_write = 1'b1;
				if (st.draw_last) begin
					state_d = post_q ? tgfw_pkg::ST_CLEAR : tgfw_pkg::ST_DONE;
				end
			end
			tgfw_pkg::ST_READ: begin
				cmd.read_issue = 1'b1;
				state_d = tgfw_pkg::ST_READ_WAIT;
			end
			tgfw_pkg::ST_READ_WAIT: begin
				cmd.read_capture = 1'b1;
				state_d = tgfw_pkg::ST_DONE;
			end
			tgfw_pkg::ST_DONE: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					cmd.finish = 1'b1;
					state_d = tgfw_pkg::ST_IDLE;
				end
			end
			default: state_d = tgfw_pkg::ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ----- src/tgfw_dp.sv -----
`default_nettype none
module tgfw_dp #(
	parameter int PixelColumns = tgfw_pkg::PixelColumnsDefault,
	parameter int TextPages = tgfw_pkg::TextPagesDefault
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tgfw_pkg::cmd_t cmd,
	output tgfw_pkg::stat_t     st,
	input  wire logic           cfg_we,
	input  wire logic [2:0]     cfg_data,
	input  wire logic [2:0]     action,
	input  wire logic [7:0]     char_code,
	input  wire logic [2:0]     target_line,
	input  wire logic [4:0]     target_cell,
	input  wire logic [8:0]     read_address,
	output logic                status,
	output logic [7:0]          read_data,
	output logic                store_cleared,
	output logic [1:0]          flow_line_now,
	output logic [6:0]          flow_column_now,
	output logic [1:0]          cursor_line_now,
	output logic [4:0]          cursor_cell_now
);

	localparam int StoreBytes = PixelColumns * TextPages;
	localparam int AW = $clog2(StoreBytes);
	localparam int CW = $clog2(PixelColumns + 1);
	localparam int CellsPerLine = PixelColumns / tgfw_pkg::CellWidth;
	localparam int NW = $clog2(CellsPerLine + 1);
	localparam int LW = 4;

	// Configuration and request registers.
	logic [2:0] lines_q;
	logic [2:0] act_q;
	logic [7:0] code_q;
	logic [2:0] tline_q;
	logic [4:0] tcell_q;
	logic [8:0] raddr_q;

	// Positions.
	logic [LW-1:0] fline_q;
	logic [CW-1:0] fcol_q;
	logic [LW-1:0] cline_q;
	logic [NW-1:0] ccell_q;

	// Draw and clear sequencing.
	logic [AW:0]   base_q;
	logic [2:0]    k_q;
	logic [AW-1:0] sweep_q;
	logic          status_q, cleared_q;
	logic [7:0]    rdata_q;

	logic [LW-1:0] lines_n;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;
	logic          ram_we;
	logic [AW:0]   draw_addr;

	// Effective line count.
	always_comb begin
		if (lines_q == 3'd0) begin
			lines_n = LW'(1);
		end else if (32'(lines_q) > TextPages) begin
			lines_n = LW'(TextPages);
		end else begin
			lines_n = LW'(lines_q);
		end
	end

	// Decision status for the controller.
	logic flow_pre, flow_wrap, flow_wrap_clear, cur_ok, cur_wrap_clear, nl_clear;
	always_comb begin
		flow_pre = fline_q >= lines_n;
		flow_wrap = (32'(fcol_q) + tgfw_pkg::CellWidth) > PixelColumns;
		flow_wrap_clear = flow_wrap && ((fline_q + LW'(1)) >= lines_n);
		cur_ok = 32'(ccell_q) < CellsPerLine;
		cur_wrap_clear = cur_ok && (32'(ccell_q) + 1 >= CellsPerLine) &&
			((cline_q + LW'(1)) >= lines_n);
		nl_clear = (fline_q + LW'(1)) >= lines_n;
		st = '0;
		case (tgfw_pkg::action_t'(act_q))
			tgfw_pkg::ACT_DRAW_FLOW: begin
				st.need_pre_clear = flow_pre || (!flow_pre && flow_wrap_clear);
				st.do_draw = 1'b1;
			end
			tgfw_pkg::ACT_DRAW_CURSOR: begin
				st.do_draw = cur_ok;
				st.need_post_clear = cur_wrap_clear;
			end
			tgfw_pkg::ACT_NEWLINE: st.need_pre_clear = nl_clear;
			tgfw_pkg::ACT_CLEAR: st.need_pre_clear = 1'b1;
			tgfw_pkg::ACT_READ: st.is_read = 1'b1;
			default: ;
		endcase
		st.clear_last = sweep_q == AW'(StoreBytes - 1);
		st.draw_last = k_q == 3'(tgfw_pkg::CellWidth - 1);
	end

	assign draw_addr = base_q + (AW + 1)'(k_q);

	// Frame store port control.
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = sweep_q;
		ram_wdata = 8'h00;
		if (cmd.clear_write) begin
			ram_we = 1'b1;
		end else if (cmd.draw_write) begin
			ram_we = 32'(draw_addr) < StoreBytes;
			ram_waddr = draw_addr[AW-1:0];
			ram_wdata = tgfw_pkg::glyph_col(code_q, k_q);
		end
		ram_raddr = AW'(raddr_q);
	end

	tgfw_ram #(.Width(8), .Depth(StoreBytes)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			act_q <= action;
			code_q <= char_code;
			tline_q <= target_line;
			tcell_q <= target_cell;
			raddr_q <= read_address;
		end
	end

	// Control state, positions and sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q <= 3'd4;
			fline_q <= '0;
			fcol_q <= '0;
			cline_q <= '0;
			ccell_q <= '0;
			base_q <= '0;
			k_q <= '0;
			sweep_q <= '0;
			status_q <= 1'b0;
			cleared_q <= 1'b0;
			rdata_q <= 8'h00;
		end else begin
			if (cfg_we) begin
				lines_q <= cfg_data;
			end
			if (cmd.load_req) begin
				status_q <= 1'b0;
				cleared_q <= 1'b0;
				rdata_q <= 8'h00;
				k_q <= '0;
				sweep_q <= '0;
			end
			if (cmd.decide) begin
				case (tgfw_pkg::action_t'(act_q))
					tgfw_pkg::ACT_DRAW_FLOW: begin
						if (!flow_pre && flow_wrap) begin
							fline_q <= fline_q + LW'(1);
							fcol_q <= CW'(tgfw_pkg::CellWidth);
						end else begin
							fcol_q <= fcol_q + CW'(tgfw_pkg::CellWidth);
						end
						// Flow draw base; a clear sends it to the origin.
						if (flow_pre || flow_wrap_clear) begin
							base_q <= '0;
						end else if (flow_wrap) begin
							base_q <= (AW + 1)'((32'(fline_q) + 1) * PixelColumns);
						end else begin
							base_q <= (AW + 1)'(32'(fline_q) * PixelColumns + 32'(fcol_q));
						end
					end
					tgfw_pkg::ACT_DRAW_CURSOR: begin
						base_q <= (AW + 1)'(32'(cline_q) * PixelColumns +
							32'(ccell_q) * tgfw_pkg::CellWidth);
						if (cur_ok) begin
							if (32'(ccell_q) + 1 >= CellsPerLine) begin
								ccell_q <= '0;
								cline_q <= cline_q + LW'(1);
							end else begin
								ccell_q <= ccell_q + NW'(1);
							end
						end
					end
					tgfw_pkg::ACT_SET_CURSOR: begin
						if (32'(tline_q) >= 32'(lines_n) || 32'(tcell_q) >= CellsPerLine) begin
							status_q <= 1'b1;
						end else begin
							cline_q <= LW'(tline_q);
							ccell_q <= NW'(tcell_q);
						end
					end
					tgfw_pkg::ACT_NEWLINE: begin
						fline_q <= fline_q + LW'(1);
						fcol_q <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.clear_write) begin
				sweep_q <= sweep_q + AW'(1);
			end
			if (cmd.clear_positions) begin
				cleared_q <= 1'b1;
				cline_q <= '0;
				ccell_q <= '0;
				// A flow draw after a clear lands at the origin.
				if (tgfw_pkg::action_t'(act_q) == tgfw_pkg::ACT_DRAW_FLOW) begin
					fline_q <= '0;
					fcol_q <= CW'(tgfw_pkg::CellWidth);
				end else begin
					fline_q <= '0;
					fcol_q <= '0;
				end
			end
			if (cmd.draw_write) begin
				k_q <= k_q + 3'd1;
			end
			if (cmd.read_capture) begin
				rdata_q <= (32'(raddr_q) < StoreBytes) ? ram_rdata : 8'h00;
			end
		end
	end

	assign status = status_q;
	assign read_data = rdata_q;
	assign store_cleared = cleared_q;
	assign flow_line_now = fline_q[1:0];
	assign flow_column_now = 7'(fcol_q);
	assign cursor_line_now = cline_q[1:0];
	assign cursor_cell_now = 5'(ccell_q);

endmodule
`default_nettype wire

// ----- src/text_glyph_framebuffer_writer.sv -----
// Text character generator writing 5x7 glyphs into a page-organized frame store.
// Input channel: valid/stall with action, char_code, target_line, target_cell
// and read_address. One result per request on the output valid/stall channel.
// Configuration channel: valid/ready write of lines_in_use; it is taken only
// while no request is in flight and none is waiting at the input.
// From the accepted request to out_valid: a draw passes one decide state,
// then six byte writes through the single write port of the frame store; a
// read passes decide, address and registered data; set cursor, newline and
// the unused actions pass only the decide state.
// A clear sweeps all PIXEL_COLUMNS * TEXT_PAGES bytes, one per cycle, as
// part of any request that clears.
// One request is in work at a time; the next is taken in the cycle after
// the result leaves.
// After reset the store is swept to zero while input and configuration are
// held off; all positions start at zero and lines_in_use at 4.
// While the receiver stalls, the result is held and no request is taken.
`default_nettype none
module text_glyph_framebuffer_writer #(
	parameter int PIXEL_COLUMNS = tgfw_pkg::PixelColumnsDefault,
	parameter int TEXT_PAGES = tgfw_pkg::TextPagesDefault
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] action,
	input  wire logic [7:0] char_code,
	input  wire logic [2:0] target_line,
	input  wire logic [4:0] target_cell,
	input  wire logic [8:0] read_address,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            status,
	output logic [7:0]      read_data,
	output logic            store_cleared,
	output logic [1:0]      flow_line_now,
	output logic [6:0]      flow_column_now,
	output logic [1:0]      cursor_line_now,
	output logic [4:0]      cursor_cell_now,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [2:0] cfg_data
);

	tgfw_pkg::cmd_t  cmd;
	tgfw_pkg::stat_t st;

	tgfw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cfg_ready(cfg_ready),
		.st       (st),
		.cmd      (cmd)
	);

	tgfw_dp #(.PixelColumns(PIXEL_COLUMNS), .TextPages(TEXT_PAGES)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_data       (cfg_data),
		.action         (action),
		.char_code      (char_code),
		.target_line    (target_line),
		.target_cell    (target_cell),
		.read_address   (read_address),
		.status         (status),
		.read_data      (read_data),
		.store_cleared  (store_cleared),
		.flow_line_now  (flow_line_now),
		.flow_column_now(flow_column_now),
		.cursor_line_now(cursor_line_now),
		.cursor_cell_now(cursor_cell_now)
	);

endmodule
`default_nettype wire
